// ===== hw/rtl/bwh_pkg.sv =====
// ----------------------------------------------------------------------------
// bwh_pkg: shared types and constants of the window histogram
// Bin and window sizes, payload structs and the command passed from the
// front to the back through the command queue.
// ----------------------------------------------------------------------------
package bwh_pkg;

	// Histogram geometry
	localparam int BINS          = 32;
	localparam int WINDOW_FRAMES = 16;

	localparam int BIN_W   = $clog2(BINS);
	localparam int SLOT_W  = $clog2(WINDOW_FRAMES);
	localparam int HELD_W  = $clog2(WINDOW_FRAMES + 1);
	localparam int STORE_DEPTH = WINDOW_FRAMES * BINS;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	// Field widths
	localparam int CNT_W  = 16;
	localparam int SUM_W  = 20;
	localparam int HOP_W  = 5;
	localparam int WORD_W = 6;

	localparam logic [HOP_W-1:0] HOP_RESET = 5'd8;

	// Operation codes
	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_CLOSE = 1'b1;

	// Command queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic              operation;
		logic [WORD_W-1:0] word_index;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] bin_index;
		logic [SUM_W-1:0]  window_count;
		logic              last_bin;
	} out_item_t;

	typedef struct packed {
		logic             is_close;
		logic [BIN_W-1:0] bin;
	} cmd_t;

	typedef struct packed {
		logic              idle;
		logic [HELD_W-1:0] held;
	} back_status_t;

endpackage

// ===== hw/rtl/bwh_front.sv =====
// ----------------------------------------------------------------------------
// bwh_front: input acceptance and classification
// Accepts input transactions while the command queue has room, drops
// counts of words outside the histogram and forwards the rest as commands.
// ----------------------------------------------------------------------------
module bwh_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  bwh_pkg::in_item_t in_data,
	input  logic              queue_full,
	output logic              push,
	output bwh_pkg::cmd_t     push_cmd
);

	logic is_close;
	logic in_range;

	// Classify the item
	assign is_close = (in_data.operation == bwh_pkg::OP_CLOSE);
	assign in_range = (7'(in_data.word_index) < 7'(bwh_pkg::BINS));

	// Accept whenever the queue can take a command
	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full && (is_close || in_range);

	assign push_cmd.is_close = is_close;
	assign push_cmd.bin      = in_data.word_index[bwh_pkg::BIN_W-1:0];

endmodule

// ===== hw/rtl/bwh_queue.sv =====
// ----------------------------------------------------------------------------
// bwh_queue: command queue between front and back
// A short first-in first-out buffer so each side can stall on its own.
// ----------------------------------------------------------------------------
module bwh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bwh_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bwh_pkg::cmd_t pop_cmd
);

	bwh_pkg::cmd_t               entry_q [bwh_pkg::QUEUE_DEPTH];
	logic [bwh_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [bwh_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [bwh_pkg::QPTR_W:0]    count_q;
	logic                        pop;

	assign full      = (count_q == (bwh_pkg::QPTR_W+1)'(bwh_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_cmd   = entry_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/bwh_back.sv =====
// ----------------------------------------------------------------------------
// bwh_back: histogram sequencer
// Executes queued commands: counts into the frame histogram, pushes a
// closed frame into the window store and sum, emits full windows and
// subtracts the dropped frames.
// ----------------------------------------------------------------------------
module bwh_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [bwh_pkg::HOP_W-1:0]       cfg_write_data,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  bwh_pkg::cmd_t                   cmd,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bwh_pkg::out_item_t              out_data,
	output bwh_pkg::back_status_t           status
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLOSE = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;
	localparam logic [1:0] ST_HOP   = 2'd3;

	localparam logic [bwh_pkg::BIN_W-1:0]  LAST_BIN  = bwh_pkg::BIN_W'(bwh_pkg::BINS - 1);
	localparam logic [bwh_pkg::SLOT_W-1:0] LAST_SLOT =
		bwh_pkg::SLOT_W'(bwh_pkg::WINDOW_FRAMES - 1);
	localparam logic [bwh_pkg::HELD_W-1:0] FULL_HELD =
		bwh_pkg::HELD_W'(bwh_pkg::WINDOW_FRAMES);

	logic [1:0]                          state_q;
	logic [bwh_pkg::HOP_W-1:0]           hop_frames_q;
	logic [bwh_pkg::CNT_W-1:0]           hist_q [bwh_pkg::BINS];
	logic [bwh_pkg::SUM_W-1:0]           sum_q  [bwh_pkg::BINS];
	logic [bwh_pkg::BIN_W-1:0]           bin_q;
	logic [bwh_pkg::SLOT_W-1:0]          newest_q;
	logic [bwh_pkg::SLOT_W-1:0]          oldest_q;
	logic [bwh_pkg::HELD_W-1:0]          held_q;
	logic [bwh_pkg::HELD_W-1:0]          hop_left_q;
	logic                                rd_valid_s1;
	logic [bwh_pkg::BIN_W-1:0]           rd_bin_s1;
	logic [bwh_pkg::CNT_W-1:0]           rd_data_s1;
	logic [bwh_pkg::CNT_W-1:0]           store_mem [bwh_pkg::STORE_DEPTH];
	logic                                out_valid_q;
	bwh_pkg::out_item_t                  out_data_q;

	logic                                cmd_pop;
	logic                                bin_last;
	logic                                out_load;
	logic                                store_we;
	logic                                store_re;
	logic [bwh_pkg::STORE_AW-1:0]        store_waddr;
	logic [bwh_pkg::STORE_AW-1:0]        store_raddr;
	logic [bwh_pkg::SLOT_W-1:0]          newest_next;
	logic [bwh_pkg::SLOT_W-1:0]          oldest_next;
	logic [bwh_pkg::HELD_W-1:0]          hop_eff;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_pop   = cmd_valid && cmd_ready;
	assign bin_last  = (bin_q == LAST_BIN);
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	assign newest_next = (newest_q == LAST_SLOT) ? '0 : newest_q + 1'b1;
	assign oldest_next = (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;

	// Frames to drop: zero acts as one, capped at the frames held
	always_comb begin
		if (hop_frames_q == '0) begin
			hop_eff = bwh_pkg::HELD_W'(1);
		end else if (6'(hop_frames_q) > 6'(held_q)) begin
			hop_eff = held_q;
		end else begin
			hop_eff = bwh_pkg::HELD_W'(hop_frames_q);
		end
	end

	// Store addressing: slot-major, one row of bins per frame
	assign store_we    = (state_q == ST_CLOSE);
	assign store_re    = (state_q == ST_HOP);
	assign store_waddr = bwh_pkg::STORE_AW'(newest_q * bwh_pkg::BINS + bin_q);
	assign store_raddr = bwh_pkg::STORE_AW'(oldest_q * bwh_pkg::BINS + bin_q);

	// Window store memory with registered read
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_waddr] <= hist_q[bin_q];
		end
		if (store_re) begin
			rd_data_s1 <= store_mem[store_raddr];
		end
	end

	// Hold the read bin for the subtract stage
	always_ff @(posedge clk) begin
		if (store_re) begin
			rd_bin_s1 <= bin_q;
		end
	end

	// Capture the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_frames_q <= bwh_pkg::HOP_RESET;
		end else if (cfg_write_en) begin
			hop_frames_q <= cfg_write_data;
		end
	end

	// Update the frame histogram: count or clear on close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bwh_pkg::BINS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (cmd_pop && !cmd.is_close) begin
			if (hist_q[cmd.bin] != '1) begin
				hist_q[cmd.bin] <= hist_q[cmd.bin] + 1'b1;
			end
		end else if (state_q == ST_CLOSE) begin
			hist_q[bin_q] <= '0;
		end
	end

	// Update the window sum: add on close, subtract dropped frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bwh_pkg::BINS; i++) begin
				sum_q[i] <= '0;
			end
		end else if (state_q == ST_CLOSE) begin
			sum_q[bin_q] <= sum_q[bin_q] + bwh_pkg::SUM_W'(hist_q[bin_q]);
		end else if (rd_valid_s1) begin
			sum_q[rd_bin_s1] <= sum_q[rd_bin_s1] - bwh_pkg::SUM_W'(rd_data_s1);
		end
	end

	// Sequence close, emit and hop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bin_q       <= '0;
			newest_q    <= '0;
			oldest_q    <= '0;
			held_q      <= '0;
			hop_left_q  <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= store_re;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && cmd.is_close) begin
						state_q <= ST_CLOSE;
						bin_q   <= '0;
					end
				end
				ST_CLOSE: begin
					if (bin_last) begin
						newest_q <= newest_next;
						held_q   <= held_q + 1'b1;
						bin_q    <= '0;
						state_q  <= (held_q + 1'b1 == FULL_HELD) ? ST_EMIT : ST_IDLE;
					end else begin
						bin_q <= bin_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (bin_last) begin
							bin_q      <= '0;
							hop_left_q <= hop_eff;
							state_q    <= ST_HOP;
						end else begin
							bin_q <= bin_q + 1'b1;
						end
					end
				end
				ST_HOP: begin
					if (bin_last) begin
						oldest_q   <= oldest_next;
						held_q     <= held_q - 1'b1;
						hop_left_q <= hop_left_q - 1'b1;
						bin_q      <= '0;
						if (hop_left_q == bwh_pkg::HELD_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end else begin
						bin_q <= bin_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.bin_index    <= bwh_pkg::WORD_W'(bin_q);
			out_data_q.window_count <= sum_q[bin_q];
			out_data_q.last_bin     <= bin_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_data_q;
	assign status.idle = (state_q == ST_IDLE);
	assign status.held = held_q;

endmodule

// ===== hw/rtl/bow_window_histogram.sv =====
// ----------------------------------------------------------------------------
// bow_window_histogram: sliding-window bag-of-words histogram
// Counts codeword indices per frame and reports the histogram summed over
// a window of frames, one bin per result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries count and close
//   transactions. Counts of words beyond the bin range are dropped. A
//   four-entry command queue lets input be taken one per cycle while it
//   has room, even while a result waits on the output.
//   Output channel (out_valid/out_ready/out_data) carries one transaction
//   per bin, in bin order, with last_bin on the final bin.
//   cfg_write_en/cfg_write_data write hop_frames; write it only when idle.
// Sequencing (bin walk of the back sequencer, one bin per cycle; the
//   output walk holds while out_ready is low):
//   count: taken by the back part while it is idle.
//   close: a walk over all bins; when the window fills, a walk of output
//   and hop walks of subtract, with hop = hop_frames (zero as one,
//   capped at the frames held); the first result follows the close walk.
// Reset: histogram, window sum and ring pointers clear at once; no
//   clearing pass. A stalled receiver holds the output register and the
//   sequencer, and input stops once the queue fills.
// ----------------------------------------------------------------------------
module bow_window_histogram (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write_en,
	input  logic [bwh_pkg::HOP_W-1:0] cfg_write_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bwh_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bwh_pkg::out_item_t        out_data
);

	logic                  queue_full;
	logic                  push;
	bwh_pkg::cmd_t         push_cmd;
	logic                  cmd_valid;
	logic                  cmd_ready;
	bwh_pkg::cmd_t         cmd;
	bwh_pkg::back_status_t status;

	bwh_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	bwh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop_valid (cmd_valid),
		.pop_ready (cmd_ready),
		.pop_cmd   (cmd)
	);

	bwh_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.status         (status)
	);

	// A window starts only when the ring is full
	a_emit_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> status.held == bwh_pkg::HELD_W'(bwh_pkg::WINDOW_FRAMES))
		else $error("window emitted before the ring filled");

	// Bins of one window follow without a gap
	a_emit_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_bin |=> out_valid)
		else $error("gap inside an emitted window");

	// An idle sequencer leaves at most the final bin pending
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		status.idle |-> !out_valid || out_data.last_bin)
		else $error("sequencer idle with a window half sent");

endmodule
